[hw/rtl/psx_pkg.sv]
`default_nettype none
package psx_pkg;

    localparam int MAX_MIN_LENGTH = 62;
    localparam int COUNT_WIDTH    = 32;
    localparam int ADDR_W         = $clog2(MAX_MIN_LENGTH);
    localparam int LEN_W          = $clog2(MAX_MIN_LENGTH + 1);
    localparam int CFG_IDX_W      = 8;
    localparam int CFG_DATA_W     = 6;

    localparam logic [CFG_IDX_W-1:0] CFG_MIN_LENGTH = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_ALNUM_MODE = CFG_IDX_W'(1);

    typedef struct packed {
        logic             clear;
        logic             inc_strings;
        logic             inc_short;
        logic [LEN_W-1:0] add_chars;
    } t_cnt_cmd;

    typedef struct packed {
        logic [COUNT_WIDTH-1:0] strings;
        logic [COUNT_WIDTH-1:0] chars;
        logic [COUNT_WIDTH-1:0] shorts;
    } t_counts;

endpackage
`default_nettype wire

[hw/rtl/psx_buf.sv]
`default_nettype none
module psx_buf
    import psx_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [7:0]        i_wdata,
    input  wire logic              i_re,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [7:0]        o_rdata
);

    logic [7:0] r_mem [MAX_MIN_LENGTH];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

[hw/rtl/psx_cnt.sv]
`default_nettype none
module psx_cnt
    import psx_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_cnt_cmd i_cmd,
    output t_counts       o_counts
);

    t_counts r_counts;
    t_counts n_counts;

    logic [COUNT_WIDTH:0] s_str;
    logic [COUNT_WIDTH:0] s_chr;
    logic [COUNT_WIDTH:0] s_sht;

    always_comb begin
        s_str = {1'b0, r_counts.strings} + (COUNT_WIDTH+1)'(i_cmd.inc_strings);
        s_chr = {1'b0, r_counts.chars} + (COUNT_WIDTH+1)'(i_cmd.add_chars);
        s_sht = {1'b0, r_counts.shorts} + (COUNT_WIDTH+1)'(i_cmd.inc_short);
        // carry out means the count would wrap: pin it at all ones
        n_counts.strings = s_str[COUNT_WIDTH] ? '1 : s_str[COUNT_WIDTH-1:0];
        n_counts.chars   = s_chr[COUNT_WIDTH] ? '1 : s_chr[COUNT_WIDTH-1:0];
        n_counts.shorts  = s_sht[COUNT_WIDTH] ? '1 : s_sht[COUNT_WIDTH-1:0];
        if (i_cmd.clear) begin
            n_counts = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_counts <= '0;
        end else begin
            r_counts <= n_counts;
        end
    end

    assign o_counts = r_counts;

endmodule
`default_nettype wire

[hw/rtl/printable_string_extractor_core.sv]
// Printable string extractor. Bytes enter one beat at a time; a byte is captured
// (S_IDLE), then decided (S_PROC), and the decision waits while the output side stalls
// one of the beats it causes. The byte that brings a run up to min_length replays the
// held run from the character buffer, one character per cycle through its single read
// port while the output does not stall, then the byte itself. The byte flagged last adds
// a summary beat, and a close step (S_CLOSE) before it when that byte is itself
// significant. The output register frees the input side: a byte is taken while a
// result still waits. Configuration writes are always ready and must only be issued
// while idle.
`default_nettype none
module printable_string_extractor_core
    import psx_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_in_valid,
    output logic                        o_in_stall,
    input  wire logic [7:0]             i_data_byte,
    input  wire logic                   i_last,
    output logic                        o_out_valid,
    input  wire logic                   i_out_stall,
    output logic      [7:0]             o_out_char,
    output logic                        o_char_valid,
    output logic                        o_string_end,
    output logic                        o_is_summary,
    output logic      [COUNT_WIDTH-1:0] o_string_count,
    output logic      [COUNT_WIDTH-1:0] o_char_count,
    output logic      [COUNT_WIDTH-1:0] o_short_count,
    output logic                        o_last_result,
    input  wire logic                   i_cfg_valid,
    output logic                        o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  i_cfg_data
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PROC,
        S_FLUSH,
        S_EMITC,
        S_CLOSE,
        S_SUM
    } t_state;

    t_state r_state, n_state;
    logic [7:0]             r_byte, n_byte;
    logic                   r_last, n_last;
    logic [LEN_W-1:0]       r_len, n_len;
    logic                   r_qual, n_qual;
    logic [ADDR_W-1:0]      r_idx, n_idx;
    logic [CFG_DATA_W-1:0]  r_min_length, n_min_length;
    logic                   r_alnum_mode, n_alnum_mode;
    logic                   r_out_valid, n_out_valid;
    logic [7:0]             r_out_char, n_out_char;
    logic                   r_char_valid, n_char_valid;
    logic                   r_string_end, n_string_end;
    logic                   r_is_summary, n_is_summary;
    logic [COUNT_WIDTH-1:0] r_string_count, n_string_count;
    logic [COUNT_WIDTH-1:0] r_char_count, n_char_count;
    logic [COUNT_WIDTH-1:0] r_short_count, n_short_count;
    logic                   r_last_result, n_last_result;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_raddr;
    logic [7:0]        ram_rdata;
    t_cnt_cmd          cnt_cmd;
    t_counts           counts;

    logic              out_free;
    logic              sig;
    logic [LEN_W-1:0]  eff_min;
    logic [LEN_W-1:0]  len_new;
    logic              emit;
    logic [7:0]        e_char;
    logic              e_cv;
    logic              e_end;
    logic              e_sum;
    logic              e_last;

    psx_buf u_buf (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (r_byte),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    psx_cnt u_cnt (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cnt_cmd),
        .o_counts (counts)
    );

    always_comb begin
        if (r_alnum_mode) begin
            sig = (r_byte >= 8'h41 && r_byte <= 8'h5A) ||
                  (r_byte >= 8'h61 && r_byte <= 8'h7A) ||
                  (r_byte >= 8'h30 && r_byte <= 8'h39);
        end else begin
            sig = (r_byte >= 8'h20) && (r_byte <= 8'h7E);
        end
        if (r_min_length == '0) begin
            eff_min = LEN_W'(1);
        end else if (LEN_W'(r_min_length) > LEN_W'(MAX_MIN_LENGTH)) begin
            eff_min = LEN_W'(MAX_MIN_LENGTH);
        end else begin
            eff_min = LEN_W'(r_min_length);
        end
        len_new = r_len + LEN_W'(1);
    end

    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state        = r_state;
        n_byte         = r_byte;
        n_last         = r_last;
        n_len          = r_len;
        n_qual         = r_qual;
        n_idx          = r_idx;
        n_min_length   = r_min_length;
        n_alnum_mode   = r_alnum_mode;
        n_out_valid    = r_out_valid && i_out_stall;
        n_out_char     = r_out_char;
        n_char_valid   = r_char_valid;
        n_string_end   = r_string_end;
        n_is_summary   = r_is_summary;
        n_string_count = r_string_count;
        n_char_count   = r_char_count;
        n_short_count  = r_short_count;
        n_last_result  = r_last_result;
        ram_we         = 1'b0;
        ram_waddr      = r_len[ADDR_W-1:0];
        ram_re         = 1'b0;
        ram_raddr      = r_idx + ADDR_W'(1);
        cnt_cmd        = '0;
        emit           = 1'b0;
        e_char         = '0;
        e_cv           = 1'b0;
        e_end          = 1'b0;
        e_sum          = 1'b0;
        e_last         = 1'b0;

        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_MIN_LENGTH: n_min_length = i_cfg_data;
                CFG_ALNUM_MODE: n_alnum_mode = i_cfg_data[0];
                default: ;
            endcase
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_byte  = i_data_byte;
                    n_last  = i_last;
                    n_state = S_PROC;
                end
            end
            S_PROC: begin
                if (sig && r_qual) begin
                    if (out_free) begin
                        emit              = 1'b1;
                        e_char            = r_byte;
                        e_cv              = 1'b1;
                        e_last            = !r_last;
                        cnt_cmd.add_chars = LEN_W'(1);
                        n_state           = r_last ? S_CLOSE : S_IDLE;
                    end
                end else if (sig) begin
                    // an unqualified run is always shorter than the buffer
                    ram_we = 1'b1;
                    n_len  = len_new;
                    if (len_new >= eff_min) begin
                        n_qual            = 1'b1;
                        cnt_cmd.add_chars = len_new;
                        n_idx             = '0;
                        if (len_new == LEN_W'(1)) begin
                            n_state = S_EMITC;
                        end else begin
                            ram_re    = 1'b1;
                            ram_raddr = '0;
                            n_state   = S_FLUSH;
                        end
                    end else begin
                        n_state = r_last ? S_CLOSE : S_IDLE;
                    end
                end else if (r_qual) begin
                    if (out_free) begin
                        emit                = 1'b1;
                        e_end               = 1'b1;
                        e_last              = !r_last;
                        cnt_cmd.inc_strings = 1'b1;
                        n_qual              = 1'b0;
                        n_len               = '0;
                        n_state             = r_last ? S_SUM : S_IDLE;
                    end
                end else begin
                    cnt_cmd.inc_short = (r_len != '0);
                    n_len             = '0;
                    n_state           = r_last ? S_SUM : S_IDLE;
                end
            end
            S_FLUSH: begin
                // held characters, then the current byte from S_EMITC
                if (out_free) begin
                    emit   = 1'b1;
                    e_char = ram_rdata;
                    e_cv   = 1'b1;
                    if (LEN_W'(r_idx) == r_len - LEN_W'(2)) begin
                        n_state = S_EMITC;
                    end else begin
                        ram_re = 1'b1;
                        n_idx  = r_idx + ADDR_W'(1);
                    end
                end
            end
            S_EMITC: begin
                if (out_free) begin
                    emit    = 1'b1;
                    e_char  = r_byte;
                    e_cv    = 1'b1;
                    e_last  = !r_last;
                    n_state = r_last ? S_CLOSE : S_IDLE;
                end
            end
            S_CLOSE: begin
                if (r_qual) begin
                    if (out_free) begin
                        emit                = 1'b1;
                        e_end               = 1'b1;
                        cnt_cmd.inc_strings = 1'b1;
                        n_qual              = 1'b0;
                        n_len               = '0;
                        n_state             = S_SUM;
                    end
                end else begin
                    cnt_cmd.inc_short = (r_len != '0);
                    n_len             = '0;
                    n_state           = S_SUM;
                end
            end
            S_SUM: begin
                if (out_free) begin
                    emit          = 1'b1;
                    e_sum         = 1'b1;
                    e_last        = 1'b1;
                    cnt_cmd.clear = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        if (emit) begin
            n_out_valid    = 1'b1;
            n_out_char     = e_char;
            n_char_valid   = e_cv;
            n_string_end   = e_end;
            n_is_summary   = e_sum;
            n_string_count = e_sum ? counts.strings : '0;
            n_char_count   = e_sum ? counts.chars : '0;
            n_short_count  = e_sum ? counts.shorts : '0;
            n_last_result  = e_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_len        <= '0;
            r_qual       <= 1'b0;
            r_idx        <= '0;
            r_min_length <= CFG_DATA_W'(4);
            r_alnum_mode <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_len        <= n_len;
            r_qual       <= n_qual;
            r_idx        <= n_idx;
            r_min_length <= n_min_length;
            r_alnum_mode <= n_alnum_mode;
            r_out_valid  <= n_out_valid;
        end
        r_byte         <= n_byte;
        r_last         <= n_last;
        r_out_char     <= n_out_char;
        r_char_valid   <= n_char_valid;
        r_string_end   <= n_string_end;
        r_is_summary   <= n_is_summary;
        r_string_count <= n_string_count;
        r_char_count   <= n_char_count;
        r_short_count  <= n_short_count;
        r_last_result  <= n_last_result;
    end

    assign o_in_stall     = (r_state != S_IDLE);
    assign o_cfg_ready    = 1'b1;
    assign o_out_valid    = r_out_valid;
    assign o_out_char     = r_out_char;
    assign o_char_valid   = r_char_valid;
    assign o_string_end   = r_string_end;
    assign o_is_summary   = r_is_summary;
    assign o_string_count = r_string_count;
    assign o_char_count   = r_char_count;
    assign o_short_count  = r_short_count;
    assign o_last_result  = r_last_result;

endmodule
`default_nettype wire

[sim/tb_printable_string_extractor_core.sv]
module tb_printable_string_extractor_core;
    import psx_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS   = 430;
    localparam int SETTLE_CYCLES  = MAX_MIN_LENGTH + 16;
    localparam int HOLD_CYCLES    = 400;
    localparam int CYCLE_LIMIT    = 10_000_000;
    localparam int MAX_REPORTS    = 10;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_UNUSED = CFG_ALNUM_MODE + 1'b1;
    localparam logic [CFG_IDX_W-1:0] CFG_LAST_UNUSED  = {CFG_IDX_W{1'b1}};

    typedef struct packed {
        logic [7:0]             chr;
        logic                   chr_ok;
        logic                   str_end;
        logic                   summ;
        logic [COUNT_WIDTH-1:0] n_str;
        logic [COUNT_WIDTH-1:0] n_chr;
        logic [COUNT_WIDTH-1:0] n_shr;
        logic                   fin;
    } t_beat;

    typedef enum {ROW_BYTE, ROW_REG} t_row_kind;

    typedef struct {
        t_row_kind              kind;
        logic [CFG_IDX_W-1:0]   idx;
        logic [7:0]             val;
        logic                   lst;
        bit                     typed;
        int                     n_typed;
        t_beat                  beat;
    } t_row;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_in_valid;
    logic                   o_in_stall;
    logic [7:0]             i_data_byte;
    logic                   i_last;
    logic                   o_out_valid;
    logic                   i_out_stall;
    logic [7:0]             o_out_char;
    logic                   o_char_valid;
    logic                   o_string_end;
    logic                   o_is_summary;
    logic [COUNT_WIDTH-1:0] o_string_count;
    logic [COUNT_WIDTH-1:0] o_char_count;
    logic [COUNT_WIDTH-1:0] o_short_count;
    logic                   o_last_result;
    logic                   i_cfg_valid;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index;
    logic [CFG_DATA_W-1:0]  i_cfg_data;

    printable_string_extractor_core u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_data_byte    (i_data_byte),
        .i_last         (i_last),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_out_char     (o_out_char),
        .o_char_valid   (o_char_valid),
        .o_string_end   (o_string_end),
        .o_is_summary   (o_is_summary),
        .o_string_count (o_string_count),
        .o_char_count   (o_char_count),
        .o_short_count  (o_short_count),
        .o_last_result  (o_last_result),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    // extractor mirror
    logic [CFG_DATA_W-1:0]  cfg_min_len;
    logic                   cfg_alnum;
    logic [7:0]             held_chars [MAX_MIN_LENGTH];
    int                     held_len;
    logic                   run_live;
    logic [COUNT_WIDTH-1:0] n_strings;
    logic [COUNT_WIDTH-1:0] n_chars;
    logic [COUNT_WIDTH-1:0] n_short;

    t_beat  step_beats [$];
    t_beat  due_beats [$];

    int     errors;
    int     beats_checked;
    int     summaries_seen;
    int     bytes_sent;
    int     reg_writes;
    int     cycle_count;
    bit     hold_req;
    bit     hold_done;
    bit     tx_calm;
    bit     rx_calm;

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    function automatic logic [COUNT_WIDTH-1:0] sat_add(input logic [COUNT_WIDTH-1:0] a,
                                                        input int n);
        logic [COUNT_WIDTH:0] sum;
        sum = {1'b0, a} + (COUNT_WIDTH+1)'(n);
        return sum[COUNT_WIDTH] ? {COUNT_WIDTH{1'b1}} : sum[COUNT_WIDTH-1:0];
    endfunction

    function automatic bit is_sig(input logic [7:0] c);
        if (cfg_alnum)
            return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") ||
                   (c >= "0" && c <= "9");
        return c >= 8'h20 && c <= 8'h7E;
    endfunction

    function automatic int eff_min();
        if (cfg_min_len == 0)
            return 1;
        if (cfg_min_len > MAX_MIN_LENGTH)
            return MAX_MIN_LENGTH;
        return int'(cfg_min_len);
    endfunction

    function automatic t_beat char_beat(input logic [7:0] c);
        t_beat b;
        b = '0;
        b.chr = c;
        b.chr_ok = 1'b1;
        return b;
    endfunction

    function automatic t_beat summary_beat(input logic [COUNT_WIDTH-1:0] s,
                                           input logic [COUNT_WIDTH-1:0] c,
                                           input logic [COUNT_WIDTH-1:0] k);
        t_beat b;
        b = '0;
        b.summ = 1'b1;
        b.n_str = s;
        b.n_chr = c;
        b.n_shr = k;
        b.fin = 1'b1;
        return b;
    endfunction

    function automatic void close_run();
        t_beat b;
        b = '0;
        if (run_live) begin
            b.str_end = 1'b1;
            step_beats.push_back(b);
            n_strings = sat_add(n_strings, 1);
        end else if (held_len > 0) begin
            n_short = sat_add(n_short, 1);
        end
        run_live = 1'b0;
        held_len = 0;
    endfunction

    // Works out the beats one input byte causes; leaves them in step_beats.
    function automatic void scan_byte(input logic [7:0] c, input logic lst);
        step_beats.delete();
        if (is_sig(c)) begin
            if (run_live) begin
                step_beats.push_back(char_beat(c));
                n_chars = sat_add(n_chars, 1);
            end else begin
                if (held_len < MAX_MIN_LENGTH) begin
                    held_chars[held_len] = c;
                    held_len++;
                end
                if (held_len >= eff_min()) begin
                    for (int i = 0; i < held_len; i++)
                        step_beats.push_back(char_beat(held_chars[i]));
                    n_chars = sat_add(n_chars, held_len);
                    run_live = 1'b1;
                end
            end
        end else begin
            close_run();
        end
        if (lst) begin
            close_run();
            step_beats.push_back(summary_beat(n_strings, n_chars, n_short));
            n_strings = '0;
            n_chars = '0;
            n_short = '0;
        end
        foreach (step_beats[i])
            step_beats[i].fin = (i == step_beats.size() - 1);
    endfunction

    function automatic int idle_len(input int min_len);
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return min_len;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(6, 40);
    endfunction

    function automatic logic [7:0] pick_char(input bit want_sig);
        logic [7:0] c;
        do
            c = 8'($urandom_range(0, 255));
        while (is_sig(c) != want_sig);
        return c;
    endfunction

    function automatic t_row byte_row(input logic [7:0] c, input logic lst,
                                      input bit typed = 1'b0, input int n = 0,
                                      input t_beat b = '0);
        t_row r;
        r.kind = ROW_BYTE;
        r.idx = '0;
        r.val = c;
        r.lst = lst;
        r.typed = typed;
        r.n_typed = n;
        r.beat = b;
        return r;
    endfunction

    function automatic t_row reg_row(input logic [CFG_IDX_W-1:0] idx,
                                     input logic [CFG_DATA_W-1:0] v);
        t_row r;
        r = byte_row(8'(v), 1'b0);
        r.kind = ROW_REG;
        r.idx = idx;
        return r;
    endfunction

    task automatic send_byte(input logic [7:0] c, input logic lst, input bit typed = 1'b0,
                             input int n_typed = 0, input t_beat typed_beat = '0);
        int gap;
        gap = tx_calm ? 0 : idle_len(0);
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_data_byte = c;
        i_last = lst;
        do
            @(posedge i_clk);
        while (o_in_stall);
        bytes_sent++;
        scan_byte(c, lst);
        if (typed) begin
            if (n_typed > 0)
                due_beats.push_back(typed_beat);
        end else begin
            foreach (step_beats[i])
                due_beats.push_back(step_beats[i]);
        end
    endtask

    // Quiet the input, let every expected beat drain, then give the core time to finish
    // any byte that causes no beat.
    task automatic settle();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (due_beats.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] v);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = v;
        do
            @(posedge i_clk);
        while (!o_cfg_ready);
        reg_writes++;
        if (idx == CFG_MIN_LENGTH)
            cfg_min_len = v;
        else if (idx == CFG_ALNUM_MODE)
            cfg_alnum = v[0];
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    initial begin : timeout
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d beats still due", cycle_count,
                 due_beats.size());
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin : receiver
        int n;
        i_out_stall = 1'b0;
        rx_calm = 1'b0;
        forever begin
            @(negedge i_clk);
            if ($urandom_range(0, 299) == 0)
                rx_calm = ~rx_calm;
            if (hold_req) begin
                hold_req = 1'b0;
                i_out_stall = 1'b1;
                for (n = 0; n < HOLD_CYCLES; n++)
                    @(negedge i_clk);
                i_out_stall = 1'b0;
            end else if (!rx_calm && $urandom_range(0, 99) < 30) begin
                i_out_stall = 1'b1;
                repeat (idle_len(1)) @(negedge i_clk);
                i_out_stall = 1'b0;
            end else begin
                i_out_stall = 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin : check_out
        t_beat got;
        t_beat exp;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got = {o_out_char, o_char_valid, o_string_end, o_is_summary,
                   o_string_count, o_char_count, o_short_count, o_last_result};
            if (due_beats.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: unexpected beat chr=%h cv=%b end=%b sum=%b %0d/%0d/%0d lr=%b",
                             $realtime, got.chr, got.chr_ok, got.str_end, got.summ,
                             got.n_str, got.n_chr, got.n_shr, got.fin);
            end else begin
                exp = due_beats.pop_front();
                beats_checked++;
                if (got.summ)
                    summaries_seen++;
                if (got.chr !== exp.chr || got.chr_ok !== exp.chr_ok ||
                    got.str_end !== exp.str_end || got.summ !== exp.summ ||
                    got.n_str !== exp.n_str || got.n_chr !== exp.n_chr ||
                    got.n_shr !== exp.n_shr || got.fin !== exp.fin) begin
                    errors++;
                    if (errors <= MAX_REPORTS) begin
                        $display("%0t: mismatch on beat %0d", $realtime, beats_checked);
                        $display("  exp chr=%h cv=%b end=%b sum=%b %0d/%0d/%0d lr=%b",
                                 exp.chr, exp.chr_ok, exp.str_end, exp.summ,
                                 exp.n_str, exp.n_chr, exp.n_shr, exp.fin);
                        $display("  got chr=%h cv=%b end=%b sum=%b %0d/%0d/%0d lr=%b",
                                 got.chr, got.chr_ok, got.str_end, got.summ,
                                 got.n_str, got.n_chr, got.n_shr, got.fin);
                    end
                end
            end
        end
    end

    initial begin : stimulus
        t_row dir_rows [$];
        t_row row;
        int   dir_count;
        int   rand_base;
        int   phase_end;
        int   em;
        int   len;
        int   r;

        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_data_byte = '0;
        i_last = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        errors = 0;
        beats_checked = 0;
        summaries_seen = 0;
        bytes_sent = 0;
        reg_writes = 0;
        hold_req = 1'b0;
        hold_done = 1'b0;
        tx_calm = 1'b0;
        cfg_min_len = CFG_DATA_W'(4);
        cfg_alnum = 1'b0;
        held_len = 0;
        run_live = 1'b0;
        n_strings = '0;
        n_chars = '0;
        n_short = '0;

        // empty buffer straight out of reset: all-zero summary
        dir_rows.push_back(byte_row(8'h00, 1'b1, 1'b1, 1, summary_beat(0, 0, 0)));
        // run of four at the printable edges qualifies, then a DEL ends it
        dir_rows.push_back(byte_row("A", 1'b0));
        dir_rows.push_back(byte_row(8'h20, 1'b0));
        dir_rows.push_back(byte_row(8'h7E, 1'b0));
        dir_rows.push_back(byte_row("B", 1'b0));
        dir_rows.push_back(byte_row(8'h7F, 1'b0));
        dir_rows.push_back(byte_row(8'h1F, 1'b0, 1'b1, 0));
        // short run dropped silently
        dir_rows.push_back(byte_row("a", 1'b0));
        dir_rows.push_back(byte_row("b", 1'b0));
        dir_rows.push_back(byte_row(8'hFF, 1'b0, 1'b1, 0));
        dir_rows.push_back(byte_row("C", 1'b1));
        // counts were cleared by the summary
        dir_rows.push_back(byte_row(8'hFF, 1'b1, 1'b1, 1, summary_beat(0, 0, 0)));
        // minimum of zero behaves as one
        dir_rows.push_back(reg_row(CFG_MIN_LENGTH, CFG_DATA_W'(0)));
        dir_rows.push_back(byte_row("0", 1'b0));
        dir_rows.push_back(byte_row("1", 1'b0));
        // minimum above the buffer depth clamps; alnum drops the space
        dir_rows.push_back(reg_row(CFG_MIN_LENGTH, CFG_DATA_W'(63)));
        dir_rows.push_back(reg_row(CFG_ALNUM_MODE, CFG_DATA_W'(1)));
        dir_rows.push_back(byte_row(8'h20, 1'b0));
        dir_rows.push_back(byte_row("Z", 1'b0));
        dir_rows.push_back(byte_row("z", 1'b0));
        dir_rows.push_back(byte_row("9", 1'b0));
        // lowering the minimum under a held run: qualifies on the next character
        dir_rows.push_back(reg_row(CFG_MIN_LENGTH, CFG_DATA_W'(2)));
        dir_rows.push_back(byte_row("a", 1'b0));
        dir_rows.push_back(byte_row("@", 1'b0));
        dir_rows.push_back(reg_row(CFG_FIRST_UNUSED, CFG_DATA_W'(5)));
        dir_rows.push_back(reg_row(CFG_LAST_UNUSED, CFG_DATA_W'(1)));
        dir_rows.push_back(reg_row(CFG_ALNUM_MODE, CFG_DATA_W'(0)));
        dir_rows.push_back(byte_row(8'h7E, 1'b1));

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (dir_rows[i]) begin
            row = dir_rows[i];
            if (row.kind == ROW_REG) begin
                settle();
                write_reg(row.idx, row.val[CFG_DATA_W-1:0]);
            end else begin
                send_byte(row.val, row.lst, row.typed, row.n_typed, row.beat);
            end
        end
        dir_count = bytes_sent;
        rand_base = bytes_sent;

        while (bytes_sent - rand_base < RANDOM_ITEMS) begin
            settle();
            r = $urandom_range(0, 99);
            if (r < 10)
                write_reg(CFG_MIN_LENGTH, CFG_DATA_W'(0));
            else if (r < 16)
                write_reg(CFG_MIN_LENGTH, CFG_DATA_W'(63));
            else if (r < 21)
                write_reg(CFG_MIN_LENGTH, CFG_DATA_W'(MAX_MIN_LENGTH));
            else if (r < 33)
                write_reg(CFG_MIN_LENGTH, CFG_DATA_W'($urandom_range(9, 30)));
            else
                write_reg(CFG_MIN_LENGTH, CFG_DATA_W'($urandom_range(1, 8)));
            if ($urandom_range(0, 2) == 0)
                write_reg(CFG_ALNUM_MODE, CFG_DATA_W'($urandom_range(0, 63)));
            if ($urandom_range(0, 7) == 0)
                write_reg(CFG_IDX_W'($urandom_range(CFG_FIRST_UNUSED, CFG_LAST_UNUSED)),
                          CFG_DATA_W'($urandom_range(0, 63)));
            tx_calm = ($urandom_range(0, 3) == 0);
            phase_end = bytes_sent + $urandom_range(15, 45);
            while (bytes_sent < phase_end && bytes_sent - rand_base < RANDOM_ITEMS) begin
                if (!hold_done && bytes_sent - rand_base >= RANDOM_ITEMS / 2) begin
                    hold_req = 1'b1;
                    hold_done = 1'b1;
                end
                em = eff_min();
                if ($urandom_range(0, 99) < 75) begin
                    // a run that mostly lands close to the minimum
                    if ($urandom_range(0, 3) == 0)
                        len = $urandom_range(0, em + 8);
                    else
                        len = $urandom_range(em > 2 ? em - 2 : 1, em + 3);
                    for (int k = 0; k < len; k++)
                        send_byte(pick_char(1'b1), 1'b0);
                    r = $urandom_range(0, 99);
                    if (r < 60)
                        send_byte(pick_char(1'b0), 1'b0);
                    else if (r < 78)
                        send_byte(pick_char(1'b0), 1'b1);
                    else if (r < 90)
                        send_byte(pick_char(1'b1), 1'b1);
                    // otherwise the run stays open into the next run or register write
                end else begin
                    send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 19) == 0);
                end
            end
        end

        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (due_beats.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (due_beats.size() != 0) begin
            errors++;
            $display("%0d expected beats never arrived", due_beats.size());
        end

        $display("run covered %0d bytes (%0d directed), %0d beats checked, %0d summaries",
                 bytes_sent, dir_count, beats_checked, summaries_seen);
        $display("%0d register writes, one %0d-cycle output hold-off, %0d mismatches",
                 reg_writes, HOLD_CYCLES, errors);
        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
